// ===== rtl/ising_metropolis_spin_update_top_macros.svh =====
// Assertion helpers for the spin update block.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_TOP_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ISM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ISM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ism_pkg.sv =====
package ism_pkg;

   localparam int DEFAULT_SIDE = 64;

   // field widths
   localparam int COORD_W    = 6;
   localparam int DRAW_W     = 15;
   localparam int THR_W      = 16;
   localparam int MAG_W      = 14;
   localparam int ACT_W      = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int HIGH_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_HIGH = 2'd2;

   // action codes; the unused code behaves as a read
   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FLIP  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NEIGHBOR,
      ST_UPDATE
   } state_type;

endpackage

// ===== rtl/ising_metropolis_spin_update_top.sv =====
// Metropolis spin update for a SIDE x SIDE Ising lattice with periodic wrap. Each request
// carries one action in req_tuser: write one spin, read one spin, or make one flip attempt
// with a 15-bit random draw; every request returns exactly one response with the site's
// spin, a flipped flag and the running magnetization (14-bit two's complement, exact up
// to SIDE = 64). Spins live in a row-wide memory (one SIDE-bit word per lattice row) with
// two read ports and one write port; a flip attempt reads the center row and the row above
// in the accept cycle, the row below in the next cycle, and if the spin changes writes the
// center row back in the update state. Every action takes this path, and no new request is
// taken before the last one is done; a stalled response channel holds the block in the
// write-back state. A request may be accepted while the previous response still waits. The
// lattice resets to all -1 at once through one valid bit per row, so there is no clearing
// pass. The acceptance table (10 x 16-bit thresholds, fractions of 32768) is written
// through the APB port at byte addresses 0, 8 and 16; write it only while idle.
`include "ising_metropolis_spin_update_top_macros.svh"

module ising_metropolis_spin_update_top
   import ism_pkg::*;
#(
   parameter int SIDE = DEFAULT_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,

   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata, lsb up: row[5:0], column[11:6], spin_value[12], random_draw[27:13], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: action[1:0]
   input  logic [ACT_W-1:0]      req_tuser,

   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata, lsb up: spin_now[0], flipped[1], magnetization[15:2]
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int RW = $clog2(SIDE);
   localparam int LUT_DEPTH = 2 ** COORD_W;
   localparam logic [RW-1:0] LAST_IDX = RW'(SIDE - 1);
   localparam logic signed [MAG_W-1:0] TOTAL_RESET = MAG_W'(-(SIDE * SIDE));
   localparam logic signed [MAG_W-1:0] STEP_UP = MAG_W'(2);
   localparam logic signed [MAG_W-1:0] STEP_DOWN = MAG_W'(-2);

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] table_low_ff, table_mid_ff;
   logic [HIGH_W-1:0]     table_high_ff;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         table_low_ff  <= '0;
         table_mid_ff  <= '0;
         table_high_ff <= '0;
      end else if (csr_write) begin
         if (csr_idx == CSR_TABLE_LOW)  table_low_ff  <= csr_pwdata;
         if (csr_idx == CSR_TABLE_MID)  table_mid_ff  <= csr_pwdata;
         if (csr_idx == CSR_TABLE_HIGH) table_high_ff <= csr_pwdata[HIGH_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_TABLE_LOW:  csr_prdata = table_low_ff;
         CSR_TABLE_MID:  csr_prdata = table_mid_ff;
         CSR_TABLE_HIGH: csr_prdata = {{(CSR_DATA_W-HIGH_W){1'b0}}, table_high_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Coordinate wrap: 6-bit row/column reduced modulo SIDE through a constant table
   // ---------------------------------------------------------------------------------
   logic [RW-1:0] wrap_lut [LUT_DEPTH];

   for (genvar g = 0; g < LUT_DEPTH; g++) begin : g_wrap
      assign wrap_lut[g] = RW'(g % SIDE);
   end

   logic [RW-1:0] in_row, in_col, up_row;

   assign in_row = wrap_lut[req_tdata[COORD_W-1:0]];
   assign in_col = wrap_lut[req_tdata[2*COORD_W-1:COORD_W]];
   assign up_row = (in_row == '0) ? LAST_IDX : in_row - 1'b1;

   // ---------------------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------------------
   state_type state_ff, state_in;
   logic      accept, out_load;
   logic      rd_a_en, rd_b_en, mem_we;
   logic [RW-1:0] rd_b_addr;

   logic [ACT_W-1:0]  act_ff;
   logic [RW-1:0]     row_ff, col_ff;
   logic              wval_ff;
   logic [DRAW_W-1:0] draw_ff;
   logic [RW-1:0]     down_row, left_col, right_col;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic new_spin, changed;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign down_row  = (row_ff == LAST_IDX) ? '0 : row_ff + 1'b1;
   assign left_col  = (col_ff == '0) ? LAST_IDX : col_ff - 1'b1;
   assign right_col = (col_ff == LAST_IDX) ? '0 : col_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      out_load  = 1'b0;
      rd_a_en   = 1'b0;
      rd_b_en   = 1'b0;
      rd_b_addr = up_row;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_a_en  = 1'b1;
               rd_b_en  = 1'b1;
               state_in = ST_NEIGHBOR;
            end
         end
         ST_NEIGHBOR: begin
            rd_b_en   = 1'b1;
            rd_b_addr = down_row;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // request hold
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_tuser;
         row_ff  <= in_row;
         col_ff  <= in_col;
         wval_ff <= req_tdata[2*COORD_W];
         draw_ff <= req_tdata[2*COORD_W+DRAW_W:2*COORD_W+1];
      end
   end

   // ---------------------------------------------------------------------------------
   // Lattice memory: one word per row, two read ports, one write port.
   // A row never written reads as all -1 through its valid bit.
   // ---------------------------------------------------------------------------------
   logic [SIDE-1:0] lattice_mem [SIDE];
   logic [SIDE-1:0] rd_a_ff, rd_b_ff, wr_row;
   logic [SIDE-1:0] row_valid_ff;
   logic            va_ff, vb_ff;
   logic [SIDE-1:0] center_row, other_row;

   assign mem_we = out_load && changed;

   always_ff @(posedge clock) begin
      if (rd_a_en) begin
         rd_a_ff <= lattice_mem[in_row];
         va_ff   <= row_valid_ff[in_row];
      end
      if (rd_b_en) begin
         rd_b_ff <= lattice_mem[rd_b_addr];
         vb_ff   <= row_valid_ff[rd_b_addr];
      end
      if (mem_we) lattice_mem[row_ff] <= wr_row;
   end

   always_ff @(posedge clock) begin
      if (reset)       row_valid_ff <= '0;
      else if (mem_we) row_valid_ff[row_ff] <= 1'b1;
   end

   assign center_row = va_ff ? rd_a_ff : '0;
   assign other_row  = vb_ff ? rd_b_ff : '0;

   // center, left, right and upper spins picked while the lower row is read
   logic center_bit_ff, left_bit_ff, right_bit_ff, up_bit_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_NEIGHBOR) begin
         center_bit_ff <= center_row[col_ff];
         left_bit_ff   <= center_row[left_col];
         right_bit_ff  <= center_row[right_col];
         up_bit_ff     <= other_row[col_ff];
      end
   end

   // ---------------------------------------------------------------------------------
   // Update: threshold lookup, compare, new spin, row write-back
   // ---------------------------------------------------------------------------------
   logic [2:0]       plus_count;
   logic [3:0]       entry;
   logic [THR_W-1:0] thr;
   logic             do_flip;

   assign plus_count = 3'(up_bit_ff) + 3'(other_row[col_ff]) + 3'(left_bit_ff)
                     + 3'(right_bit_ff);
   assign entry = center_bit_ff ? 4'(plus_count) + 4'd5 : 4'(plus_count);

   always_comb begin
      unique case (entry)
         4'd0:    thr = table_low_ff[15:0];
         4'd1:    thr = table_low_ff[31:16];
         4'd2:    thr = table_low_ff[47:32];
         4'd3:    thr = table_low_ff[63:48];
         4'd4:    thr = table_mid_ff[15:0];
         4'd5:    thr = table_mid_ff[31:16];
         4'd6:    thr = table_mid_ff[47:32];
         4'd7:    thr = table_mid_ff[63:48];
         4'd8:    thr = table_high_ff[15:0];
         4'd9:    thr = table_high_ff[31:16];
         default: thr = '0;
      endcase
   end

   // threshold of 32768 or above always flips
   assign do_flip = {1'b0, draw_ff} < thr;

   always_comb begin
      unique case (act_ff)
         ACT_WRITE: new_spin = wval_ff;
         ACT_FLIP:  new_spin = do_flip ? ~center_bit_ff : center_bit_ff;
         default:   new_spin = center_bit_ff;
      endcase
   end

   assign changed = (new_spin != center_bit_ff);

   always_comb begin
      wr_row         = center_row;
      wr_row[col_ff] = new_spin;
   end

   // running magnetization, kept modulo 2^14
   logic signed [MAG_W-1:0] total_ff, total_in;

   always_comb begin
      total_in = total_ff;
      if (mem_we) total_in = total_ff + (new_spin ? STEP_UP : STEP_DOWN);
   end

   always_ff @(posedge clock) begin
      if (reset) total_ff <= TOTAL_RESET;
      else       total_ff <= total_in;
   end

   // ---------------------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) rsp_data_ff <= {total_in, changed, new_spin};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   `ISM_ASSERT_NEXT(a_accept_to_neighbor, clock, reset, accept, state_ff == ST_NEIGHBOR, "accepted request did not start the neighbor read")
   `ISM_ASSERT_NOW(a_write_in_update, clock, reset, mem_we, state_ff == ST_UPDATE && out_load, "lattice written outside the update transfer")
   `ISM_ASSERT_NEXT(a_read_no_flip, clock, reset, out_load && act_ff != ACT_WRITE && act_ff != ACT_FLIP, !rsp_tdata[1] && $stable(total_ff), "read action changed the lattice")
   `ISM_ASSERT_NEXT(a_flip_moves_total, clock, reset, out_load && changed, total_ff != $past(total_ff), "spin change without magnetization update")

endmodule
